// ----- design/skt_pkg.sv -----
// Shared constants, types and gap table for the sorted key table lookup.
`timescale 1ns / 1ps

package skt_pkg;

  localparam int DEF_TABLE_DEPTH = 256;
  localparam int DEF_KEY_BITS    = 32;
  localparam int DEF_VALUE_BITS  = 16;

  localparam int GAP_COUNT = 11;
  localparam int GAP_W     = 13;
  localparam int GIDX_W    = 4;

  localparam logic REQ_LOAD   = 1'b0;
  localparam logic REQ_LOOKUP = 1'b1;

  typedef enum logic [2:0] {
    ST_STORED   = 3'd0,
    ST_SORTED   = 3'd1,
    ST_FOUND    = 3'd2,
    ST_MISS     = 3'd3,
    ST_FULL     = 3'd4,
    ST_UNSEALED = 3'd5
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_GAP,
    S_RD_I,
    S_LD_I,
    S_RD_J,
    S_CMP_J,
    S_SR_PROBE,
    S_SR_CMP,
    S_SR_CHK,
    S_SR_DONE
  } state_e;

  // Shell sort gap sequence.
  function automatic logic [GAP_W-1:0] gap_at(input logic [GIDX_W-1:0] idx);
    logic [GAP_W-1:0] g;
    case (idx)
      4'd0:    g = 13'd1;
      4'd1:    g = 13'd4;
      4'd2:    g = 13'd9;
      4'd3:    g = 13'd20;
      4'd4:    g = 13'd46;
      4'd5:    g = 13'd103;
      4'd6:    g = 13'd233;
      4'd7:    g = 13'd525;
      4'd8:    g = 13'd1182;
      4'd9:    g = 13'd2660;
      4'd10:   g = 13'd5985;
      default: g = 13'd0;
    endcase
    return g;
  endfunction

endpackage

// ----- design/skt_ram.sv -----
// Generic single write port, single read port RAM with registered read.
`timescale 1ns / 1ps

module skt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- design/skt_seq.sv -----
// Sequencer: table load, Shell sort and binary search over the shared RAM port.
`timescale 1ns / 1ps

module skt_seq
  import skt_pkg::*;
#(
  parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
  parameter int KEY_BITS    = DEF_KEY_BITS,
  parameter int VALUE_BITS  = DEF_VALUE_BITS,
  localparam int AW         = $clog2(TABLE_DEPTH),
  localparam int CW         = $clog2(TABLE_DEPTH + 1),
  localparam int DW         = KEY_BITS + VALUE_BITS
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // request side
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic                  req_type_i,
  input  logic [KEY_BITS-1:0]   entry_key_i,
  input  logic [VALUE_BITS-1:0] entry_value_i,
  input  logic                  entry_last_i,
  input  logic [KEY_BITS-1:0]   search_key_i,
  // result side
  input  logic                  out_free_i,
  output logic                  push_o,
  output status_e               res_status_o,
  output logic [VALUE_BITS-1:0] res_value_o,
  output logic [CW-1:0]         res_pos_o,
  output logic [CW-1:0]         res_count_o,
  // RAM port
  output logic                  we_o,
  output logic [AW-1:0]         waddr_o,
  output logic [DW-1:0]         wdata_o,
  output logic                  re_o,
  output logic [AW-1:0]         raddr_o,
  input  logic [DW-1:0]         rdata_i
);

  localparam int WIDE_W = (CW > GAP_W) ? CW : GAP_W;

  state_e              state_q, state_d;
  logic [CW-1:0]       count_q, count_d;
  logic                sealed_q, sealed_d;
  logic [GIDX_W-1:0]   gi_q, gi_d;
  logic [CW-1:0]       gap_q, gap_d;
  logic [CW-1:0]       i_q, i_d;
  logic [CW-1:0]       j_q, j_d;
  logic [DW-1:0]       tmp_q, tmp_d;
  logic [KEY_BITS-1:0] skey_q, skey_d;
  logic [CW-1:0]       lo_q, lo_d;
  logic [CW-1:0]       hi_q, hi_d;
  logic [CW-1:0]       mid_q, mid_d;
  status_e             rstat_q, rstat_d;
  logic [VALUE_BITS-1:0] rval_q, rval_d;

  logic [KEY_BITS-1:0] rd_key;
  logic [KEY_BITS-1:0] tmp_key;
  logic [CW:0]         mid_sum;
  logic [CW-1:0]       base;
  logic [CW-1:0]       jm_gap;
  logic                accept;

  assign rd_key  = rdata_i[DW-1:VALUE_BITS];
  assign tmp_key = tmp_q[DW-1:VALUE_BITS];
  assign mid_sum = {1'b0, lo_q} + {1'b0, hi_q};
  assign base    = sealed_q ? '0 : count_q;
  assign jm_gap  = j_q - gap_q;
  assign in_ready_o = (state_q == S_IDLE) && out_free_i;
  assign accept  = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      count_q  <= '0;
      sealed_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      sealed_q <= sealed_d;
    end
  end

  always_ff @(posedge clk_i) begin
    gi_q    <= gi_d;
    gap_q   <= gap_d;
    i_q     <= i_d;
    j_q     <= j_d;
    tmp_q   <= tmp_d;
    skey_q  <= skey_d;
    lo_q    <= lo_d;
    hi_q    <= hi_d;
    mid_q   <= mid_d;
    rstat_q <= rstat_d;
    rval_q  <= rval_d;
  end

  always_comb begin
    state_d  = state_q;
    count_d  = count_q;
    sealed_d = sealed_q;
    gi_d     = gi_q;
    gap_d    = gap_q;
    i_d      = i_q;
    j_d      = j_q;
    tmp_d    = tmp_q;
    skey_d   = skey_q;
    lo_d     = lo_q;
    hi_d     = hi_q;
    mid_d    = mid_q;
    rstat_d  = rstat_q;
    rval_d   = rval_q;

    push_o       = 1'b0;
    res_status_o = rstat_q;
    res_value_o  = rval_q;
    res_pos_o    = lo_q;
    res_count_o  = count_q;

    we_o    = 1'b0;
    waddr_o = j_q[AW-1:0];
    wdata_o = tmp_q;
    re_o    = 1'b0;
    raddr_o = i_q[AW-1:0];

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (req_type_i == REQ_LOAD) begin
            push_o      = 1'b1;
            res_value_o = '0;
            res_pos_o   = '0;
            if (base != CW'(TABLE_DEPTH)) begin
              we_o         = 1'b1;
              waddr_o      = base[AW-1:0];
              wdata_o      = {entry_key_i, entry_value_i};
              count_d      = base + CW'(1);
              res_status_o = entry_last_i ? ST_SORTED : ST_STORED;
            end else begin
              count_d      = base;
              res_status_o = ST_FULL;
            end
            res_count_o = count_d;
            sealed_d    = entry_last_i;
            if (entry_last_i && (count_d > CW'(1))) begin
              gi_d    = '0;
              state_d = S_GAP;
            end
          end else if (!sealed_q) begin
            push_o       = 1'b1;
            res_status_o = ST_UNSEALED;
            res_value_o  = '0;
            res_pos_o    = '0;
          end else begin
            skey_d  = search_key_i;
            lo_d    = '0;
            hi_d    = count_q;
            state_d = S_SR_PROBE;
          end
        end
      end

      // pick the first gap: walk up while the next gap is below the count
      S_GAP: begin
        if ((gi_q + GIDX_W'(1) < GIDX_W'(GAP_COUNT)) &&
            (WIDE_W'(count_q) > WIDE_W'(gap_at(gi_q + GIDX_W'(1))))) begin
          gi_d = gi_q + GIDX_W'(1);
        end else begin
          gap_d   = CW'(gap_at(gi_q));
          i_d     = CW'(gap_at(gi_q));
          state_d = S_RD_I;
        end
      end

      S_RD_I: begin
        if (i_q < count_q) begin
          re_o    = 1'b1;
          raddr_o = i_q[AW-1:0];
          state_d = S_LD_I;
        end else if (gi_q == '0) begin
          state_d = S_IDLE;
        end else begin
          gi_d  = gi_q - GIDX_W'(1);
          gap_d = CW'(gap_at(gi_q - GIDX_W'(1)));
          i_d   = CW'(gap_at(gi_q - GIDX_W'(1)));
        end
      end

      S_LD_I: begin
        tmp_d   = rdata_i;
        j_d     = i_q;
        state_d = S_RD_J;
      end

      S_RD_J: begin
        if (j_q >= gap_q) begin
          re_o    = 1'b1;
          raddr_o = jm_gap[AW-1:0];
          state_d = S_CMP_J;
        end else begin
          we_o    = 1'b1;
          i_d     = i_q + CW'(1);
          state_d = S_RD_I;
        end
      end

      S_CMP_J: begin
        we_o = 1'b1;
        if (rd_key > tmp_key) begin
          wdata_o = rdata_i;
          j_d     = j_q - gap_q;
          state_d = S_RD_J;
        end else begin
          i_d     = i_q + CW'(1);
          state_d = S_RD_I;
        end
      end

      S_SR_PROBE: begin
        if (lo_q < hi_q) begin
          mid_d   = mid_sum[CW:1];
          re_o    = 1'b1;
          raddr_o = mid_sum[AW:1];
          state_d = S_SR_CMP;
        end else if (lo_q < count_q) begin
          re_o    = 1'b1;
          raddr_o = lo_q[AW-1:0];
          state_d = S_SR_CHK;
        end else begin
          rstat_d = ST_MISS;
          rval_d  = '0;
          state_d = S_SR_DONE;
        end
      end

      S_SR_CMP: begin
        if (rd_key < skey_q) begin
          lo_d = mid_q + CW'(1);
        end else begin
          hi_d = mid_q;
        end
        state_d = S_SR_PROBE;
      end

      S_SR_CHK: begin
        if (rd_key == skey_q) begin
          rstat_d = ST_FOUND;
          rval_d  = rdata_i[VALUE_BITS-1:0];
        end else begin
          rstat_d = ST_MISS;
          rval_d  = '0;
        end
        state_d = S_SR_DONE;
      end

      S_SR_DONE: begin
        if (out_free_i) begin
          push_o  = 1'b1;
          state_d = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(TABLE_DEPTH))
    else $error("entry count beyond table depth");

  a_sort_sealed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_GAP || state_q == S_RD_I || state_q == S_LD_I ||
     state_q == S_RD_J || state_q == S_CMP_J) |-> sealed_q)
    else $error("sort running on an unsealed table");

  a_shift_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RD_J || state_q == S_CMP_J) |-> (j_q <= i_q && i_q < count_q))
    else $error("insertion index out of order");

  a_search_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SR_PROBE || state_q == S_SR_CMP) |-> (lo_q <= hi_q && hi_q <= count_q))
    else $error("search window inverted");

  a_push_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o |-> out_free_i)
    else $error("result pushed into a full output register");
`endif

endmodule

// ----- design/sorted_key_table_lookup.sv -----
// Top level of the sorted key table lookup engine.
`timescale 1ns / 1ps

// Key/value dispatch table. A load transaction (req_type 0) appends a
// (key, value) pair; the load marked last seals the table and Shell sorts
// it by key (gaps 1,4,9,20,46,...). A lookup transaction (req_type 1) runs a
// lower-bound binary search and returns the value and position. Status:
// 0 stored, 1 stored and sorted, 2 found, 3 not found, 4 table full (entry
// dropped), 5 lookup before sealing. A load after a seal starts a new table.
// A last load is followed by the sort: the first gap is picked, then a gap
// pass runs for each gap down to 1, reading each element and shifting
// larger keys up by the gap. A lookup probes the midpoint until the
// window closes, then reads the entry at the bound to check it; that
// read is skipped when the search ends past the last entry. The entry
// RAM has no reset and needs no clearing pass: only written entries are
// ever read. A finished result sits in an output register; a new
// transaction is taken only while that register is empty or being
// drained in the same cycle, and never while a sort or a search is
// running.

module sorted_key_table_lookup
  import skt_pkg::*;
#(
  parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
  parameter int KEY_BITS    = DEF_KEY_BITS,
  parameter int VALUE_BITS  = DEF_VALUE_BITS,
  localparam int CW         = $clog2(TABLE_DEPTH + 1)
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic                  req_type_i,
  input  logic [KEY_BITS-1:0]   entry_key_i,
  input  logic [VALUE_BITS-1:0] entry_value_i,
  input  logic                  entry_last_i,
  input  logic [KEY_BITS-1:0]   search_key_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [2:0]            status_o,
  output logic [VALUE_BITS-1:0] found_value_o,
  output logic [CW-1:0]         found_position_o,
  output logic [CW-1:0]         table_count_o
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int DW = KEY_BITS + VALUE_BITS;

  logic                  out_free;
  logic                  push;
  status_e               res_status;
  logic [VALUE_BITS-1:0] res_value;
  logic [CW-1:0]         res_pos;
  logic [CW-1:0]         res_count;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [DW-1:0] ram_wdata;
  logic          ram_re;
  logic [AW-1:0] ram_raddr;
  logic [DW-1:0] ram_rdata;

  // output register
  logic                  out_valid_q;
  logic [2:0]            status_q;
  logic [VALUE_BITS-1:0] value_q;
  logic [CW-1:0]         pos_q;
  logic [CW-1:0]         count_q;

  // slot is free when empty or being drained this cycle
  assign out_free = !out_valid_q || out_ready_i;

  skt_seq #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .KEY_BITS    (KEY_BITS),
    .VALUE_BITS  (VALUE_BITS)
  ) u_seq (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .req_type_i    (req_type_i),
    .entry_key_i   (entry_key_i),
    .entry_value_i (entry_value_i),
    .entry_last_i  (entry_last_i),
    .search_key_i  (search_key_i),
    .out_free_i    (out_free),
    .push_o        (push),
    .res_status_o  (res_status),
    .res_value_o   (res_value),
    .res_pos_o     (res_pos),
    .res_count_o   (res_count),
    .we_o          (ram_we),
    .waddr_o       (ram_waddr),
    .wdata_o       (ram_wdata),
    .re_o          (ram_re),
    .raddr_o       (ram_raddr),
    .rdata_i       (ram_rdata)
  );

  // entry store: {key, value} per row
  skt_ram #(
    .WIDTH (DW),
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (push) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      status_q <= res_status;
      value_q  <= res_value;
      pos_q    <= res_pos;
      count_q  <= res_count;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign status_o         = status_q;
  assign found_value_o    = value_q;
  assign found_position_o = pos_q;
  assign table_count_o    = count_q;

endmodule

// ----- dv/sorted_key_table_lookup_tb.sv -----
// Testbench for the sorted key table lookup engine: directed and random transactions.
`timescale 1ns / 1ps

module sorted_key_table_lookup_tb;
  import skt_pkg::*;

  localparam int TABLE_DEPTH = DEF_TABLE_DEPTH;
  localparam int KEY_BITS    = DEF_KEY_BITS;
  localparam int VALUE_BITS  = DEF_VALUE_BITS;
  localparam int CW          = $clog2(TABLE_DEPTH + 1);
  localparam int ITEM_TARGET = 1850;
  localparam int TAIL_CYCLES = 40;

  typedef logic [KEY_BITS-1:0]   key_t;
  typedef logic [VALUE_BITS-1:0] value_t;

  // One lookup/load response as the block should return it.
  typedef struct packed {
    status_e       st;
    value_t        value;
    logic [CW-1:0] pos;
    logic [CW-1:0] count;
  } table_resp_t;

  logic          clk_i = 1'b0;
  logic          rst_ni;
  logic          in_valid_i;
  logic          in_ready_o;
  logic          req_type_i;
  key_t          entry_key_i;
  value_t        entry_value_i;
  logic          entry_last_i;
  key_t          search_key_i;
  logic          out_valid_o;
  logic          out_ready_i;
  logic [2:0]    status_o;
  value_t        found_value_o;
  logic [CW-1:0] found_position_o;
  logic [CW-1:0] table_count_o;

  sorted_key_table_lookup u_top (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .req_type_i       (req_type_i),
    .entry_key_i      (entry_key_i),
    .entry_value_i    (entry_value_i),
    .entry_last_i     (entry_last_i),
    .search_key_i     (search_key_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .status_o         (status_o),
    .found_value_o    (found_value_o),
    .found_position_o (found_position_o),
    .table_count_o    (table_count_o)
  );

  always #6 clk_i = ~clk_i;

  // Shadow copy of the table and its seal.
  key_t        tbl_key [TABLE_DEPTH];
  value_t      tbl_val [TABLE_DEPTH];
  int unsigned tbl_n;
  bit          tbl_sealed;
  int unsigned shell_gaps [0:10] = '{1, 4, 9, 20, 46, 103, 233, 525, 1182, 2660, 5985};

  table_resp_t expected_resp_q [$];
  int unsigned items_sent;
  int unsigned mismatch_cnt;
  bit          idle_on;

  // Shell sort of the first n shadow entries, largest usable gap first.
  function automatic void shell_sort_table(int unsigned n);
    int          gi;
    int unsigned gap;
    int unsigned i;
    int unsigned j;
    key_t        k;
    value_t      v;
    if (n <= 1) return;
    gi = 0;
    while (gi + 1 < GAP_COUNT && n > shell_gaps[gi + 1]) gi++;
    while (gi >= 0) begin
      gap = shell_gaps[gi];
      for (i = gap; i < n; i++) begin
        k = tbl_key[i];
        v = tbl_val[i];
        j = i;
        while (j >= gap && tbl_key[j - gap] > k) begin
          tbl_key[j] = tbl_key[j - gap];
          tbl_val[j] = tbl_val[j - gap];
          j -= gap;
        end
        tbl_key[j] = k;
        tbl_val[j] = v;
      end
      gi--;
    end
  endfunction

  // Updates the shadow table for one transaction and returns its response.
  function automatic table_resp_t table_response(logic rt, key_t ekey, value_t evalue,
                                                 logic elast, key_t skey);
    table_resp_t r;
    int unsigned lo;
    int unsigned hi;
    int unsigned mid;
    r = '0;
    if (rt == REQ_LOAD) begin
      // A load after a seal throws the old table away.
      if (tbl_sealed) begin
        tbl_n      = 0;
        tbl_sealed = 1'b0;
      end
      if (tbl_n < TABLE_DEPTH) begin
        tbl_key[tbl_n] = ekey;
        tbl_val[tbl_n] = evalue;
        tbl_n++;
        r.st = elast ? ST_SORTED : ST_STORED;
      end else begin
        r.st = ST_FULL;
      end
      if (elast) begin
        shell_sort_table(tbl_n);
        tbl_sealed = 1'b1;
      end
    end else if (!tbl_sealed) begin
      r.st = ST_UNSEALED;
    end else begin
      // Lower-bound search: first position whose key is not below skey.
      lo = 0;
      hi = tbl_n;
      while (lo < hi) begin
        mid = (lo + hi) >> 1;
        if (tbl_key[mid] < skey) lo = mid + 1;
        else hi = mid;
      end
      r.pos = CW'(lo);
      if (lo < tbl_n && tbl_key[lo] == skey) begin
        r.st    = ST_FOUND;
        r.value = tbl_val[lo];
      end else begin
        r.st = ST_MISS;
      end
    end
    r.count = CW'(tbl_n);
    return r;
  endfunction

  // Idle length: mostly none or short, now and then long; zero in burst stretches.
  function automatic int unsigned pick_idle();
    int unsigned r;
    if (!idle_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Keys drawn to give duplicates, extremes and wide spreads.
  function automatic key_t rand_key();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 40) return key_t'($urandom_range(0, 15));
    if (r < 50) return '1;
    if (r < 55) return '1 - 1;
    if (r < 60) return {1'b1, {(KEY_BITS - 1){1'b0}}};
    return key_t'($urandom());
  endfunction

  // Search keys: mostly keys held in the table, some neighbors, some random.
  function automatic key_t pick_search_key();
    int unsigned r;
    key_t        k;
    if (tbl_n == 0) return rand_key();
    k = tbl_key[$urandom_range(0, tbl_n - 1)];
    r = $urandom_range(0, 99);
    if (r < 60) return k;
    if (r < 68) return k + 1;
    if (r < 76) return k - 1;
    return rand_key();
  endfunction

  // Drives one transaction, holds it until taken, then records its response.
  task automatic send_req(input logic rt, input key_t ekey, input value_t evalue,
                          input logic elast, input key_t skey);
    int unsigned gap;
    gap = pick_idle();
    @(negedge clk_i);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i    <= 1'b1;
    req_type_i    <= rt;
    entry_key_i   <= ekey;
    entry_value_i <= evalue;
    entry_last_i  <= elast;
    search_key_i  <= skey;
    do @(posedge clk_i); while (!in_ready_o);
    expected_resp_q.push_back(table_response(rt, ekey, evalue, elast, skey));
    items_sent++;
  endtask

  // Fields that a transaction does not use carry random noise.
  task automatic load_entry(input key_t k, input value_t v, input logic last);
    send_req(REQ_LOAD, k, v, last, key_t'($urandom()));
  endtask

  task automatic lookup_key(input key_t k);
    send_req(REQ_LOOKUP, key_t'($urandom()), value_t'($urandom()), 1'($urandom()), k);
  endtask

  // Sender goes quiet until every outstanding response has been returned.
  task automatic drain_results();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (expected_resp_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic check_field(input string fname, input logic [31:0] exp_v,
                             input logic [31:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s mismatch: expected 0x%0h, actual 0x%0h", fname, exp_v, act_v);
      mismatch_cnt++;
    end
  endtask

  // Response checker: every accepted response against the oldest expectation.
  always @(posedge clk_i) begin : resp_check
    table_resp_t exp_r;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_resp_q.size() == 0) begin
        $error("response with nothing outstanding: status %0d", status_o);
        mismatch_cnt++;
      end else begin
        exp_r = expected_resp_q.pop_front();
        check_field("status", 32'(exp_r.st), 32'(status_o));
        check_field("found_value", 32'(exp_r.value), 32'(found_value_o));
        check_field("found_position", 32'(exp_r.pos), 32'(found_position_o));
        check_field("table_count", 32'(exp_r.count), 32'(table_count_o));
      end
    end
  end

  // Response side backpressure: ready held for a while, then a random stall.
  initial begin : out_stall
    int unsigned stall;
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      out_ready_i <= 1'b1;
      repeat ($urandom_range(1, 12)) @(negedge clk_i);
      stall = pick_idle();
      if (stall != 0) begin
        out_ready_i <= 1'b0;
        repeat (stall - 1) @(negedge clk_i);
      end
    end
  end

  // Lookups before any seal, including one in the middle of loading.
  task automatic test_unsealed_lookups();
    lookup_key('0);
    lookup_key('1);
    load_entry(key_t'(32'h0000_0042), value_t'(16'h0042), 1'b0);
    lookup_key(key_t'(32'h0000_0042));
  endtask

  // Small table with key and value extremes, a duplicate key, hits and misses.
  task automatic test_directed_table();
    load_entry(key_t'(5), value_t'(16'h1234), 1'b0);
    load_entry('1, '1, 1'b0);
    load_entry('0, '0, 1'b0);
    load_entry(key_t'(5), value_t'(16'hAAAA), 1'b0);
    load_entry(key_t'(7), value_t'(16'h0001), 1'b1);
    lookup_key(key_t'(5));
    lookup_key('0);
    lookup_key('1);
    lookup_key(key_t'(6));
    lookup_key(key_t'(3));
    lookup_key('1 - 1);
    // Single entry table; the load starts a fresh table after the seal.
    load_entry(key_t'(100), value_t'(16'h5555), 1'b1);
    lookup_key(key_t'(99));
    lookup_key(key_t'(100));
    lookup_key(key_t'(101));
  endtask

  // Fill the table, overflow it, seal with a dropped last entry, then search.
  task automatic test_full_table();
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      load_entry(rand_key(), value_t'($urandom()), 1'b0);
      if (i == TABLE_DEPTH / 2) drain_results();
    end
    load_entry(rand_key(), value_t'($urandom()), 1'b0);
    load_entry(rand_key(), value_t'($urandom()), 1'b0);
    load_entry(rand_key(), value_t'($urandom()), 1'b1);
    drain_results();
    lookup_key('0);
    lookup_key('1);
    repeat (30) lookup_key(pick_search_key());
  endtask

  // Random tables of mostly small size, searched after each seal, with some
  // lookups mixed into loading and some tables never sealed.
  task automatic test_random_tables();
    int unsigned r;
    int unsigned n;
    bit          seal;
    while (items_sent < ITEM_TARGET) begin
      idle_on = ($urandom_range(0, 3) != 0);
      r = $urandom_range(0, 99);
      if (r < 70) n = $urandom_range(1, 16);
      else if (r < 95) n = $urandom_range(17, 64);
      else n = $urandom_range(65, 200);
      seal = ($urandom_range(0, 19) != 0);
      for (int unsigned i = 0; i < n; i++) begin
        if ($urandom_range(0, 19) == 0) lookup_key(pick_search_key());
        load_entry(rand_key(), value_t'($urandom()), seal && (i == n - 1));
      end
      repeat ($urandom_range(1, 12)) lookup_key(pick_search_key());
      if ($urandom_range(0, 9) == 0) drain_results();
    end
  endtask

  initial begin
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    req_type_i    = REQ_LOAD;
    entry_key_i   = '0;
    entry_value_i = '0;
    entry_last_i  = 1'b0;
    search_key_i  = '0;
    tbl_n         = 0;
    tbl_sealed    = 1'b0;
    items_sent    = 0;
    mismatch_cnt  = 0;
    idle_on       = 1'b1;
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;

    test_unsealed_lookups();
    test_directed_table();
    test_full_table();
    test_random_tables();

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("** sorted_key_table_lookup: PASSED **");
    end else begin
      $display("** sorted_key_table_lookup: FAILED **");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest legal run.
  initial begin
    #60_000_000;
    $display("** sorted_key_table_lookup: FAILED **");
    $finish;
  end

endmodule

// ----- files.f -----
design/skt_pkg.sv
design/skt_ram.sv
design/skt_seq.sv
design/sorted_key_table_lookup.sv
dv/sorted_key_table_lookup_tb.sv
